// ----- rtl/crdp_pkg.sv -----
// ----------------------------------------------------------------------------
// crdp_pkg
// Shared types, constants and lookup tables for the cube rotate/project block.
// ----------------------------------------------------------------------------
package crdp_pkg;

	localparam int CoordW   = 16;
	localparam int ProdW    = 32;
	localparam int HalfEdge = 50;
	localparam int DepthPush = 400;
	localparam int ZNear    = 50;
	localparam int ProjScale = 100;
	localparam int FracBits = 14;

	typedef logic signed [CoordW-1:0] coord_t;

	// request to the divider
	typedef struct packed {
		logic              start;
		logic [CoordW-1:0] dividend;
		logic [CoordW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [CoordW-1:0] quotient;
	} div_rsp_t;

	// Q14 sine, 64 steps per turn
	function automatic coord_t sin_q14(input logic [5:0] idx);
		coord_t r;
		case (idx)
			6'd0: r = 16'sd0;       6'd1: r = 16'sd1606;    6'd2: r = 16'sd3196;
			6'd3: r = 16'sd4756;    6'd4: r = 16'sd6270;    6'd5: r = 16'sd7723;
			6'd6: r = 16'sd9102;    6'd7: r = 16'sd10394;   6'd8: r = 16'sd11585;
			6'd9: r = 16'sd12665;   6'd10: r = 16'sd13623;  6'd11: r = 16'sd14449;
			6'd12: r = 16'sd15137;  6'd13: r = 16'sd15679;  6'd14: r = 16'sd16069;
			6'd15: r = 16'sd16305;  6'd16: r = 16'sd16384;  6'd17: r = 16'sd16305;
			6'd18: r = 16'sd16069;  6'd19: r = 16'sd15679;  6'd20: r = 16'sd15137;
			6'd21: r = 16'sd14449;  6'd22: r = 16'sd13623;  6'd23: r = 16'sd12665;
			6'd24: r = 16'sd11585;  6'd25: r = 16'sd10394;  6'd26: r = 16'sd9102;
			6'd27: r = 16'sd7723;   6'd28: r = 16'sd6270;   6'd29: r = 16'sd4756;
			6'd30: r = 16'sd3196;   6'd31: r = 16'sd1606;   6'd32: r = 16'sd0;
			6'd33: r = -16'sd1605;  6'd34: r = -16'sd3195;  6'd35: r = -16'sd4755;
			6'd36: r = -16'sd6269;  6'd37: r = -16'sd7722;  6'd38: r = -16'sd9101;
			6'd39: r = -16'sd10393; 6'd40: r = -16'sd11584; 6'd41: r = -16'sd12664;
			6'd42: r = -16'sd13622; 6'd43: r = -16'sd14448; 6'd44: r = -16'sd15136;
			6'd45: r = -16'sd15678; 6'd46: r = -16'sd16068; 6'd47: r = -16'sd16304;
			6'd48: r = -16'sd16383; 6'd49: r = -16'sd16304; 6'd50: r = -16'sd16068;
			6'd51: r = -16'sd15678; 6'd52: r = -16'sd15136; 6'd53: r = -16'sd14448;
			6'd54: r = -16'sd13622; 6'd55: r = -16'sd12664; 6'd56: r = -16'sd11584;
			6'd57: r = -16'sd10393; 6'd58: r = -16'sd9101;  6'd59: r = -16'sd7722;
			6'd60: r = -16'sd6269;  6'd61: r = -16'sd4755;  6'd62: r = -16'sd3195;
			default: r = -16'sd1605;
		endcase
		return r;
	endfunction

	function automatic coord_t cos_q14(input logic [5:0] idx);
		return sin_q14(idx + 6'd16);
	endfunction

	// corner j of face f
	function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [1:0] j);
		logic [11:0] row;
		case (f)
			3'd0: row = {3'd3, 3'd2, 3'd1, 3'd0};
			3'd1: row = {3'd7, 3'd6, 3'd5, 3'd4};
			3'd2: row = {3'd4, 3'd5, 3'd1, 3'd0};
			3'd3: row = {3'd2, 3'd6, 3'd7, 3'd3};
			3'd4: row = {3'd5, 3'd6, 3'd2, 3'd1};
			default: row = {3'd4, 3'd7, 3'd3, 3'd0};
		endcase
		return row[j*3 +: 3];
	endfunction

endpackage

// ----- rtl/crdp_div.sv -----
// ----------------------------------------------------------------------------
// crdp_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crdp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  crdp_pkg::div_req_t req,
	output crdp_pkg::div_rsp_t rsp
);
	localparam int W = crdp_pkg::CoordW;

	logic [W-1:0]   quo_q;
	logic [W-1:0]   den_q;
	logic [W:0]     rem_q;
	logic [4:0]     cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W:0]     shifted;
	logic [W:0]     diff;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == 5'(W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: shift one dividend bit into the remainder, subtract when it fits
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start |=> (busy_q || done_q))
		else $error("divider run dropped");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done longer than one cycle");
`endif

endmodule

// ----- rtl/cube_rotate_project_depth_sort.sv -----
// ----------------------------------------------------------------------------
// cube_rotate_project_depth_sort
// Cube rotation, perspective projection and painter's-order face selection.
// ----------------------------------------------------------------------------
// Each accepted word (yaw_index, pitch_index) starts one frame: the eight cube
// vertices are rotated about Y then X with a single shared 16x16 multiplier
// (nine S_ROT multiply steps per vertex, plus S_MULY), projected through
// one shared restoring divider (a launch state then a wait state per axis, x
// then y), the six face depths are summed one corner per cycle, the faces
// are ranked by a scan of one face per cycle, and the three nearest quads plus
// the bounding box go out as four words. A frame is shorter when a vertex
// falls behind the near plane or off screen, since its divides are skipped,
// and any output stall lengthens it; the divider waits take most of its time.
// in_stall is high for the whole frame. Configuration writes are taken at
// any time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module cube_rotate_project_depth_sort (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [6:0]  yaw_index,
	input  logic [6:0]  pitch_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [2:0]  face,
	output logic signed [15:0] ax,
	output logic signed [15:0] ay,
	output logic signed [15:0] bx,
	output logic signed [15:0] by,
	output logic [7:0]  cx,
	output logic [7:0]  cy,
	output logic [7:0]  dx,
	output logic [7:0]  dy,
	output logic        last
);

	typedef enum logic [3:0] {
		S_IDLE, S_ROT, S_DIVX, S_WAITX, S_MULY, S_DIVY, S_WAITY, S_NEXTV,
		S_DEPTH, S_SORT, S_LOAD, S_EMIT, S_BOX
	} state_t;

	localparam logic [0:0] RegWidth  = 1'b0;
	localparam logic [0:0] RegHeight = 1'b1;

	state_t state_q;
	logic [7:0] width_q, height_q;
	logic [5:0] yaw_q, pitch_q;
	logic [2:0] v_q;
	logic [3:0] ms_q;
	logic signed [31:0] acc_q;
	crdp_pkg::coord_t x1_q, z1_q, y2_q, z2_q;

	logic signed [15:0] vz_q [8];
	logic [7:0] mem_x_q [8];
	logic [7:0] mem_y_q [8];
	logic [7:0] vld_x_q, vld_y_q;
	logic [7:0] rx_q, ry_q;

	logic signed [15:0] depth_q [6];
	logic signed [15:0] dsum_q;
	logic [2:0] f_q;
	logic [1:0] j_q;

	logic [5:0] used_q;
	logic [2:0] k_q, i_q, best_q;
	logic       have_q;
	logic signed [15:0] best_d_q;
	logic [2:0] cnt_q;

	logic signed [15:0] xmin_q, xmax_q, ymin_q, ymax_q;

	// shared multiplier
	crdp_pkg::coord_t ma, mb, xv, yv, zv;
	logic signed [31:0] prod, sum, shr;

	// divider
	crdp_pkg::div_req_t dreq;
	crdp_pkg::div_rsp_t drsp;
	logic signed [16:0] quo_s, half, tq;
	logic               proj_ok;
	logic [7:0]         proj_p, span;
	logic signed [15:0] proj_w;

	// sort scan
	logic       take;
	logic [2:0] nb;
	logic signed [15:0] nd;
	logic [2:0] rd_addr;

	assign xv = (v_q[0] ^ v_q[1]) ? 16'(crdp_pkg::HalfEdge) : -16'(crdp_pkg::HalfEdge);
	assign yv = v_q[2] ? 16'(crdp_pkg::HalfEdge) : -16'(crdp_pkg::HalfEdge);
	assign zv = !v_q[1] ? 16'(crdp_pkg::HalfEdge) : -16'(crdp_pkg::HalfEdge);

	always_comb begin
		ma = x1_q;
		mb = 16'(crdp_pkg::ProjScale);
		if (state_q == S_MULY) begin
			ma = y2_q;
		end else begin
			case (ms_q)
				4'd0: begin ma = xv;  mb = crdp_pkg::cos_q14(yaw_q); end
				4'd1: begin ma = zv;  mb = crdp_pkg::sin_q14(yaw_q); end
				4'd2: begin ma = -xv; mb = crdp_pkg::sin_q14(yaw_q); end
				4'd3: begin ma = zv;  mb = crdp_pkg::cos_q14(yaw_q); end
				4'd4: begin ma = yv;  mb = crdp_pkg::cos_q14(pitch_q); end
				4'd5: begin ma = z1_q; mb = crdp_pkg::sin_q14(pitch_q); end
				4'd6: begin ma = -yv; mb = crdp_pkg::sin_q14(pitch_q); end
				4'd7: begin ma = z1_q; mb = crdp_pkg::cos_q14(pitch_q); end
				default: begin ma = x1_q; mb = 16'(crdp_pkg::ProjScale); end
			endcase
		end
	end

	assign prod = ma * mb;
	assign sum  = acc_q + prod;
	assign shr  = sum >>> crdp_pkg::FracBits;

	// divider hookup: magnitude of the scaled coordinate over the depth
	assign dreq.start    = (state_q == S_DIVX) || (state_q == S_DIVY);
	assign dreq.dividend = acc_q[31] ? 16'(-acc_q) : acc_q[15:0];
	assign dreq.divisor  = z2_q;

	crdp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// acc_q still holds the signed dividend while the divider runs
	assign quo_s   = {1'b0, drsp.quotient};
	assign tq      = acc_q[31] ? -quo_s : quo_s;
	assign span    = (state_q == S_WAITY) ? height_q : width_q;
	assign half    = {10'd0, span[7:1]};
	assign proj_ok = (tq >= -half) && (tq <= half - 17'sd1);
	assign proj_p  = tq[7:0] + half[7:0];
	assign proj_w  = {8'd0, proj_p};

	// one face per cycle; strictly deeper wins, so ties keep the lower index
	assign take = !used_q[i_q] && (!have_q || (depth_q[i_q] > best_d_q));
	assign nb   = take ? i_q : best_q;
	assign nd   = take ? depth_q[i_q] : best_d_q;

	assign rd_addr = crdp_pkg::face_corner(best_q, cnt_q[1:0]);

	assign in_stall = (state_q != S_IDLE);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd96;
			height_q <= 8'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegWidth:  width_q  <= cfg_data;
				RegHeight: height_q <= cfg_data;
			endcase
		end
	end

	// vertex coordinate store, one write and one read a cycle
	always_ff @(posedge clk) begin
		if (state_q == S_WAITX && drsp.done && proj_ok) mem_x_q[v_q] <= proj_p;
		if (state_q == S_WAITY && drsp.done && proj_ok) mem_y_q[v_q] <= proj_p;
		rx_q <= vld_x_q[rd_addr] ? mem_x_q[rd_addr] : 8'd0;
		ry_q <= vld_y_q[rd_addr] ? mem_y_q[rd_addr] : 8'd0;
	end

	// sequencer with datapath and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			vld_x_q   <= '0;
			vld_y_q   <= '0;
			ms_q      <= '0;
			v_q       <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
			i_q       <= '0;
			f_q       <= '0;
			j_q       <= '0;
			used_q    <= '0;
			have_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						yaw_q   <= yaw_index[5:0];
						pitch_q <= pitch_index[5:0];
						v_q     <= '0;
						ms_q    <= '0;
						acc_q   <= '0;
						xmin_q  <= 16'sd32767;
						ymin_q  <= 16'sd32767;
						xmax_q  <= -16'sd32767;
						ymax_q  <= -16'sd32767;
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					ms_q <= ms_q + 4'd1;
					case (ms_q)
						4'd1: x1_q <= shr[15:0];
						4'd3: z1_q <= shr[15:0];
						4'd5: y2_q <= shr[15:0];
						4'd7: begin
							z2_q <= shr[15:0] + 16'(crdp_pkg::DepthPush);
							vz_q[v_q] <= shr[15:0] + 16'(crdp_pkg::DepthPush);
						end
						default: ;
					endcase
					// even steps load the first product; step 8 loads 100*x1
					if (ms_q[0] == 1'b0) acc_q <= prod;
					else                 acc_q <= '0;
					if (ms_q == 4'd8) begin
						state_q <= (z2_q >= 16'(crdp_pkg::ZNear)) ? S_DIVX : S_NEXTV;
					end
				end
				S_DIVX: state_q <= S_WAITX;
				S_WAITX: begin
					if (drsp.done) begin
						if (proj_ok) begin
							vld_x_q[v_q] <= 1'b1;
							if (proj_w < xmin_q) xmin_q <= proj_w;
							if (proj_w > xmax_q) xmax_q <= proj_w;
							state_q <= S_MULY;
						end else begin
							state_q <= S_NEXTV;
						end
					end
				end
				S_MULY: begin
					acc_q   <= prod;
					state_q <= S_DIVY;
				end
				S_DIVY: state_q <= S_WAITY;
				S_WAITY: begin
					if (drsp.done) begin
						if (proj_ok) begin
							vld_y_q[v_q] <= 1'b1;
							if (proj_w < ymin_q) ymin_q <= proj_w;
							if (proj_w > ymax_q) ymax_q <= proj_w;
						end
						state_q <= S_NEXTV;
					end
				end
				S_NEXTV: begin
					ms_q  <= '0;
					acc_q <= '0;
					v_q   <= v_q + 3'd1;
					if (v_q == 3'd7) begin
						f_q     <= '0;
						j_q     <= '0;
						dsum_q  <= '0;
						state_q <= S_DEPTH;
					end else begin
						state_q <= S_ROT;
					end
				end
				S_DEPTH: begin
					// accumulate one corner; depths are positive, so >>2 truncates
					j_q <= j_q + 2'd1;
					if (j_q == 2'd3) begin
						depth_q[f_q] <= (dsum_q + vz_q[crdp_pkg::face_corner(f_q, j_q)]) >>> 2;
						dsum_q <= '0;
						f_q    <= f_q + 3'd1;
						if (f_q == 3'd5) begin
							used_q  <= '0;
							k_q     <= '0;
							i_q     <= '0;
							have_q  <= 1'b0;
							state_q <= S_SORT;
						end
					end else begin
						dsum_q <= dsum_q + vz_q[crdp_pkg::face_corner(f_q, j_q)];
					end
				end
				S_SORT: begin
					best_q   <= nb;
					best_d_q <= nd;
					if (i_q == 3'd5) begin
						used_q[nb] <= 1'b1;
						i_q        <= '0;
						have_q     <= 1'b0;
						cnt_q      <= '0;
						if (k_q >= 3'd3) begin
							state_q <= S_LOAD;
						end else begin
							k_q <= k_q + 3'd1;
						end
					end else begin
						// a candidate exists only once an unused face was seen
						have_q <= have_q | take;
						i_q    <= i_q + 3'd1;
					end
				end
				S_LOAD: begin
					// read data is registered, so it arrives in the cycle after its corner address
					cnt_q <= cnt_q + 3'd1;
					case (cnt_q)
						3'd1: begin ax <= 16'(rx_q); ay <= 16'(ry_q); end
						3'd2: begin bx <= 16'(rx_q); by <= 16'(ry_q); end
						3'd3: begin cx <= rx_q; cy <= ry_q; end
						3'd4: begin dx <= rx_q; dy <= ry_q; end
						default: ;
					endcase
					if (cnt_q == 3'd4) begin
						kind      <= 1'b0;
						face      <= best_q;
						last      <= 1'b0;
						out_valid <= 1'b1;
						state_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_stall) begin
						if (k_q == 3'd5) begin
							kind    <= 1'b1;
							face    <= '0;
							last    <= 1'b1;
							ax      <= xmin_q;
							ay      <= ymin_q;
							bx      <= xmax_q;
							by      <= ymax_q;
							cx      <= '0;
							cy      <= '0;
							dx      <= '0;
							dy      <= '0;
							state_q <= S_BOX;
						end else begin
							out_valid <= 1'b0;
							k_q       <= k_q + 3'd1;
							state_q   <= S_SORT;
						end
					end
				end
				S_BOX: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == S_EMIT || state_q == S_BOX))
		else $error("result word outside an emit state");
	a_last_is_box: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == kind))
		else $error("last flag does not match box word");
	a_sort_used: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SORT |-> $countones(used_q) <= 5)
		else $error("face ranking ran out of faces");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("taking a frame while a word is pending");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Frame-level check of cube_rotate_project_depth_sort: directed and random
// yaw/pitch words are sent under random gaps and output stalls. A predictor
// computes the three painter's-order quads and the bounding box of each frame,
// and every output word is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumRandom = 230;
	localparam logic CfgWidth  = 1'b0;
	localparam logic CfgHeight = 1'b1;
	localparam logic KindQuad = 1'b0;
	localparam logic KindBox  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [2:0]  face;
		logic signed [15:0] ax, ay, bx, by;
		logic [7:0]  cx, cy, dx, dy;
		logic        last;
	} frame_word_t;

	typedef struct {
		logic [6:0] yaw;
		logic [6:0] pitch;
		bit         typed;   // box word typed in below
		logic signed [15:0] bmin_x, bmin_y, bmax_x, bmax_y;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [6:0] yaw_index = '0;
	logic [6:0] pitch_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind, last;
	logic [2:0] face;
	logic signed [15:0] ax, ay, bx, by;
	logic [7:0] cx, cy, dx, dy;

	cube_rotate_project_depth_sort DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the block state
	logic [7:0] scr_w, scr_h;
	logic [7:0] vert_x [8];
	logic [7:0] vert_y [8];
	frame_word_t expected_words [$];
	int mismatches = 0;
	bit stim_done = 1'b0;

	// corner signs of the model cube on each axis
	function automatic int corner_sign(int v, int axis);
		case (axis)
			0: return (v == 1 || v == 2 || v == 5 || v == 6) ? 1 : -1;
			1: return (v >= 4) ? 1 : -1;
			default: return (v == 0 || v == 1 || v == 4 || v == 5) ? 1 : -1;
		endcase
	endfunction

	function automatic int floor_shift14(int v);
		return v >>> 14;
	endfunction

	function automatic bit on_screen(int c, int z, logic [7:0] span, output int pos);
		int half, t;
		half = span / 2;
		t = (100 * c) / z;
		pos = t + half;
		return t >= -half && t <= half - 1;
	endfunction

	// rotate, project and sort one frame, update state and queue four words
	task automatic predict_frame(logic [6:0] yaw_in, logic [6:0] pitch_in);
		logic [5:0] yi, pi;
		int sy, cyw, sp, cp, x, y, z, x1, z1, y2, z2, p;
		int vz [8];
		int depth [6];
		bit taken [6];
		int xmin, ymin, xmax, ymax, best;
		logic [2:0] c0, c1, c2, c3;
		frame_word_t w;
		yi = yaw_in[5:0];
		pi = pitch_in[5:0];
		sy = crdp_pkg::sin_q14(yi);
		cyw = crdp_pkg::cos_q14(yi);
		sp = crdp_pkg::sin_q14(pi);
		cp = crdp_pkg::cos_q14(pi);
		xmin = 32767; ymin = 32767; xmax = -32767; ymax = -32767;
		for (int i = 0; i < 8; i++) begin
			x = corner_sign(i, 0) * 50;
			y = corner_sign(i, 1) * 50;
			z = corner_sign(i, 2) * 50;
			x1 = floor_shift14(x * cyw + z * sy);
			z1 = floor_shift14(-x * sy + z * cyw);
			y2 = floor_shift14(y * cp + z1 * sp);
			z2 = floor_shift14(-y * sp + z1 * cp) + 400;
			vz[i] = z2;
			if (z2 >= 50 && on_screen(x1, z2, scr_w, p)) begin
				vert_x[i] = p[7:0];
				if (p < xmin) xmin = p;
				if (p > xmax) xmax = p;
				if (on_screen(y2, z2, scr_h, p)) begin
					vert_y[i] = p[7:0];
					if (p < ymin) ymin = p;
					if (p > ymax) ymax = p;
				end
			end
		end
		for (int f = 0; f < 6; f++) begin
			depth[f] = 0;
			for (int j = 0; j < 4; j++)
				depth[f] += vz[crdp_pkg::face_corner(3'(f), 2'(j))];
			depth[f] = depth[f] / 4;
			taken[f] = 1'b0;
		end
		// farthest first; strict compare keeps the lower index on a tie
		for (int k = 0; k < 6; k++) begin
			best = -1;
			for (int f = 0; f < 6; f++)
				if (!taken[f] && (best < 0 || depth[f] > depth[best])) best = f;
			taken[best] = 1'b1;
			if (k >= 3) begin
				c0 = crdp_pkg::face_corner(3'(best), 2'd0);
				c1 = crdp_pkg::face_corner(3'(best), 2'd1);
				c2 = crdp_pkg::face_corner(3'(best), 2'd2);
				c3 = crdp_pkg::face_corner(3'(best), 2'd3);
				w.kind = KindQuad;
				w.face = 3'(best);
				w.ax = {8'd0, vert_x[c0]}; w.ay = {8'd0, vert_y[c0]};
				w.bx = {8'd0, vert_x[c1]}; w.by = {8'd0, vert_y[c1]};
				w.cx = vert_x[c2]; w.cy = vert_y[c2];
				w.dx = vert_x[c3]; w.dy = vert_y[c3];
				w.last = 1'b0;
				expected_words.push_back(w);
			end
		end
		w = '0;
		w.kind = KindBox;
		w.ax = 16'(xmin); w.ay = 16'(ymin);
		w.bx = 16'(xmax); w.by = 16'(ymax);
		w.last = 1'b1;
		expected_words.push_back(w);
	endtask

	// mostly short gaps, now and then a long one, sometimes none
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic write_reg(logic idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CfgWidth) scr_w = val;
		else scr_h = val;
	endtask

	// hold the word until accepted; with no gap the next word follows at once
	task automatic send_frame(logic [6:0] yaw_in, logic [6:0] pitch_in);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		yaw_index <= yaw_in;
		pitch_index <= pitch_in;
		do @(posedge clk); while (in_stall);
		predict_frame(yaw_in, pitch_in);
	endtask

	// drop valid, wait for the pipeline to drain, plus a margin for the last word
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// output stall: random runs, with stretches of no stall at all
	int stall_left = 0;
	bit calm = 1'b0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			stall_left <= gap_len();
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
		if ($urandom_range(0, 199) == 0) calm <= !calm;
	end

	// compare every accepted output word with the oldest expectation
	always @(posedge clk) begin
		frame_word_t got, exp_w;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, face, ax, ay, bx, by, cx, cy, dx, dy, last};
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", got);
			end else begin
				exp_w = expected_words.pop_front();
				if (got !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h got %h", exp_w, got);
				end
			end
		end
	end

	stim_row_t rows [$];

	task automatic add_row(logic [6:0] y, logic [6:0] p);
		stim_row_t r;
		r = '{y, p, 1'b0, 0, 0, 0, 0};
		rows.push_back(r);
	endtask

	initial begin
		stim_row_t r;
		int k, sz;
		logic [7:0] sizes [6];
		sizes = '{8'd2, 8'd254, 8'd3, 8'd40, 8'd160, 8'd96};
		for (int i = 0; i < 8; i++) begin
			vert_x[i] = '0;
			vert_y[i] = '0;
		end
		scr_w = 8'd96;
		scr_h = 8'd64;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset sizes, cardinal angles, index 64 and the top of the range
		add_row(7'd0, 7'd0);
		add_row(7'd64, 7'd64);
		add_row(7'd127, 7'd127);
		add_row(7'd16, 7'd0);
		add_row(7'd32, 7'd0);
		add_row(7'd48, 7'd16);
		add_row(7'd8, 7'd8);
		add_row(7'd5, 7'd58);
		add_row(7'd85, 7'd42);
		add_row(7'd0, 7'd16);
		add_row(7'd0, 7'd48);
		add_row(7'd63, 7'd63);
		foreach (rows[i]) send_frame(rows[i].yaw, rows[i].pitch);
		drain();

		// tiny screen: nothing lands, so the box keeps its sentinels
		write_reg(CfgWidth, 8'd2);
		write_reg(CfgHeight, 8'd2);
		rows.delete();
		r = '{7'd16, 7'd0, 1'b1, 16'sd32767, 16'sd32767, -16'sd32767, -16'sd32767};
		rows.push_back(r);
		add_row(7'd0, 7'd0);
		add_row(7'd20, 7'd44);
		foreach (rows[i]) begin
			send_frame(rows[i].yaw, rows[i].pitch);
			if (rows[i].typed) begin
				// the box word is the newest expectation; its fields are known
				sz = expected_words.size();
				if (expected_words[sz-1].ax !== rows[i].bmin_x ||
				    expected_words[sz-1].ay !== rows[i].bmin_y ||
				    expected_words[sz-1].bx !== rows[i].bmax_x ||
				    expected_words[sz-1].by !== rows[i].bmax_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("box mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
							rows[i].bmin_x, rows[i].bmin_y, rows[i].bmax_x,
							rows[i].bmax_y, expected_words[sz-1].ax,
							expected_words[sz-1].ay, expected_words[sz-1].bx,
							expected_words[sz-1].by);
				end
			end
		end
		drain();

		// widest screen, then random frames through a sweep of sizes
		write_reg(CfgWidth, 8'd254);
		write_reg(CfgHeight, 8'd254);
		add_row(7'd4, 7'd60);
		send_frame(7'd4, 7'd60);
		drain();

		for (int n = 0; n < NumRandom; n++) begin
			if (n % 40 == 0) begin
				drain();
				write_reg(CfgWidth, sizes[(n / 40) % 6]);
				write_reg(CfgHeight, sizes[(n / 40 + 3) % 6] ^ 8'($urandom_range(0, 1)));
			end
			// hold off until every word of the earlier frames has come
			if (n == 100) begin
				in_valid <= 1'b0;
				while (expected_words.size() != 0) @(posedge clk);
			end
			k = $urandom_range(0, 9);
			if (k == 0)
				send_frame(7'($urandom_range(64, 127)), 7'($urandom_range(64, 127)));
			else
				send_frame(7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)));
		end
		drain();
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end
endmodule
